// ===== sv/cpet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpet_pkg
// Shared types, widths and helpers for the collision pair event tracker.
// ----------------------------------------------------------------------------
package cpet_pkg;

  localparam int ID_BITS_DEF = 6;
  localparam int POS_W       = 24;
  localparam int SIZE_W      = 16;
  // half size in 1/256 pixel: size * 50, at most 65535 * 50
  localparam int HALF_W      = 22;
  localparam int RSUM_W      = HALF_W + 1;
  localparam int RDIFF_W     = POS_W + 1;
  localparam int CDIFF_W     = POS_W + 2;
  localparam int CMAG_W      = CDIFF_W - 1;
  localparam int SQ_W        = 2 * CMAG_W;
  localparam int SQR_W       = 2 * RSUM_W;

  typedef enum logic [1:0] {
    SHAPE_RECT_RECT = 2'd0,
    SHAPE_CIRC_RECT = 2'd1,
    SHAPE_RECT_CIRC = 2'd2,
    SHAPE_CIRC_CIRC = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } ev_t;

  typedef enum logic {
    KIND_TEST  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SQR,
    ST_EVAL
  } st_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic sqr;
    logic eval;
    logic clr_wr;
    logic clr_emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

  // size * 50 as shift and add
  function automatic logic [HALF_W-1:0] half_size(input logic [SIZE_W-1:0] s);
    logic [HALF_W-1:0] e;
    e = HALF_W'(s);
    return (e << 5) + (e << 4) + (e << 1);
  endfunction

endpackage
`default_nettype wire

// ===== sv/collision_pair_event_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// test item: result strobed on done after the calc, square and evaluate steps,
//   with the flag row read registered at accept; no new item until back in idle
// clear item: result strobed the next cycle, then busy while all
//   2**ID_BITS flag rows are zeroed, one row per cycle (64 at ID_BITS = 6)
// reset: the same row sweep runs, busy stays high until it ends
// done is high for one cycle per item and the receiver cannot stall it
// ----------------------------------------------------------------------------
// collision_pair_event_tracker_core
// Rect and circle overlap test with per-pair enter, stay and exit tracking.
// ----------------------------------------------------------------------------
module collision_pair_event_tracker_core #(
  parameter int ID_BITS = cpet_pkg::ID_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire                               kind,
  input  wire        [ID_BITS-1:0]          left_id,
  input  wire        [ID_BITS-1:0]          right_id,
  input  wire signed [cpet_pkg::POS_W-1:0]  left_x,
  input  wire signed [cpet_pkg::POS_W-1:0]  left_y,
  input  wire        [cpet_pkg::SIZE_W-1:0] left_w,
  input  wire        [cpet_pkg::SIZE_W-1:0] left_h,
  input  wire signed [cpet_pkg::POS_W-1:0]  right_x,
  input  wire signed [cpet_pkg::POS_W-1:0]  right_y,
  input  wire        [cpet_pkg::SIZE_W-1:0] right_w,
  input  wire        [cpet_pkg::SIZE_W-1:0] right_h,
  input  wire        [1:0]                  shapes,
  output logic                              done,
  output logic       [1:0]                  event_res,
  output logic                              hit
);

  cpet_pkg::cmd_t    cmd;
  cpet_pkg::status_t status;

  cpet_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cpet_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .left_id   (left_id),
    .right_id  (right_id),
    .left_x    (left_x),
    .left_y    (left_y),
    .left_w    (left_w),
    .left_h    (left_h),
    .right_x   (right_x),
    .right_y   (right_y),
    .right_w   (right_w),
    .right_h   (right_h),
    .shapes    (shapes),
    .done      (done),
    .event_res (event_res),
    .hit       (hit)
  );

endmodule
`default_nettype wire

// ===== sv/cpet_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpet_ctrl
// Sequencer: row clear sweep, then test steps calc, square and evaluate.
// ----------------------------------------------------------------------------
module cpet_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire                     kind,
  input  wire cpet_pkg::status_t  status,
  output cpet_pkg::cmd_t          cmd,
  output logic                    busy
);

  cpet_pkg::st_t state;
  cpet_pkg::st_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpet_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      cpet_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = cpet_pkg::ST_IDLE;
        end
      end
      cpet_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (kind == cpet_pkg::KIND_CLEAR) begin
            cmd.clr_emit = 1'b1;
            state_next   = cpet_pkg::ST_CLEAR;
          end else begin
            cmd.load   = 1'b1;
            state_next = cpet_pkg::ST_CALC;
          end
        end
      end
      cpet_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = cpet_pkg::ST_SQR;
      end
      cpet_pkg::ST_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = cpet_pkg::ST_EVAL;
      end
      cpet_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = cpet_pkg::ST_IDLE;
      end
      default: begin
        state_next = cpet_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/cpet_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpet_dp
// Overlap arithmetic, pair flag row memory and result registers.
// ----------------------------------------------------------------------------
module cpet_dp #(
  parameter int ID_BITS = cpet_pkg::ID_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire cpet_pkg::cmd_t              cmd,
  output cpet_pkg::status_t                status,
  input  wire        [ID_BITS-1:0]         left_id,
  input  wire        [ID_BITS-1:0]         right_id,
  input  wire signed [cpet_pkg::POS_W-1:0] left_x,
  input  wire signed [cpet_pkg::POS_W-1:0] left_y,
  input  wire        [cpet_pkg::SIZE_W-1:0] left_w,
  input  wire        [cpet_pkg::SIZE_W-1:0] left_h,
  input  wire signed [cpet_pkg::POS_W-1:0] right_x,
  input  wire signed [cpet_pkg::POS_W-1:0] right_y,
  input  wire        [cpet_pkg::SIZE_W-1:0] right_w,
  input  wire        [cpet_pkg::SIZE_W-1:0] right_h,
  input  wire        [1:0]                 shapes,
  output logic                             done,
  output logic       [1:0]                 event_res,
  output logic                             hit
);

  localparam int ROWS = 1 << ID_BITS;

  // one row per left id, one bit per right id
  logic [ROWS-1:0] row_mem [ROWS];
  logic [ROWS-1:0] rd_row;
  logic [ROWS-1:0] new_row;
  logic [ID_BITS-1:0] clr_cnt;
  logic [ID_BITS-1:0] li;
  logic [ID_BITS-1:0] ri;

  logic signed [cpet_pkg::POS_W-1:0] lx, ly, rx, ry;
  logic [cpet_pkg::HALF_W-1:0] lhw, lhh, rhw, rhh;
  logic [1:0] shp;

  logic [cpet_pkg::RSUM_W-1:0]  sum_w, sum_h;
  logic [cpet_pkg::RDIFF_W-1:0] adx, ady;
  logic [cpet_pkg::CMAG_W-1:0]  cdx, cdy;

  logic [cpet_pkg::SQ_W-1:0]  sq_x, sq_y;
  logic [cpet_pkg::SQR_W-1:0] sq_r;
  logic rect_hit;

  logic signed [cpet_pkg::RDIFF_W-1:0] rdx_c, rdy_c;
  logic signed [cpet_pkg::CDIFF_W-1:0] cdx_c, cdy_c;
  logic circ_hit, hit_c, was;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clr_last = &clr_cnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_row <= row_mem[left_id];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      row_mem[clr_cnt] <= '0;
    end else if (cmd.eval) begin
      row_mem[li] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      li  <= left_id;
      ri  <= right_id;
      lx  <= left_x;
      ly  <= left_y;
      rx  <= right_x;
      ry  <= right_y;
      lhw <= cpet_pkg::half_size(left_w);
      lhh <= cpet_pkg::half_size(left_h);
      rhw <= cpet_pkg::half_size(right_w);
      rhh <= cpet_pkg::half_size(right_h);
      shp <= shapes;
    end
  end

  always_comb begin
    rdx_c = cpet_pkg::RDIFF_W'(lx) - cpet_pkg::RDIFF_W'(rx);
    rdy_c = cpet_pkg::RDIFF_W'(ly) - cpet_pkg::RDIFF_W'(ry);
    // circle centers sit half a width and half a height past the position
    cdx_c = (cpet_pkg::CDIFF_W'(lx) + $signed({4'b0, lhw}))
          - (cpet_pkg::CDIFF_W'(rx) + $signed({4'b0, rhw}));
    cdy_c = (cpet_pkg::CDIFF_W'(ly) + $signed({4'b0, lhh}))
          - (cpet_pkg::CDIFF_W'(ry) + $signed({4'b0, rhh}));
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sum_w <= cpet_pkg::RSUM_W'(lhw) + cpet_pkg::RSUM_W'(rhw);
      sum_h <= cpet_pkg::RSUM_W'(lhh) + cpet_pkg::RSUM_W'(rhh);
      adx   <= rdx_c[cpet_pkg::RDIFF_W-1] ? -rdx_c : rdx_c;
      ady   <= rdy_c[cpet_pkg::RDIFF_W-1] ? -rdy_c : rdy_c;
      cdx   <= cpet_pkg::CMAG_W'(cdx_c[cpet_pkg::CDIFF_W-1] ? -cdx_c : cdx_c);
      cdy   <= cpet_pkg::CMAG_W'(cdy_c[cpet_pkg::CDIFF_W-1] ? -cdy_c : cdy_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sq_x     <= cpet_pkg::SQ_W'(cdx) * cpet_pkg::SQ_W'(cdx);
      sq_y     <= cpet_pkg::SQ_W'(cdy) * cpet_pkg::SQ_W'(cdy);
      sq_r     <= cpet_pkg::SQR_W'(sum_w) * cpet_pkg::SQR_W'(sum_w);
      rect_hit <= (cpet_pkg::RDIFF_W'(sum_w) > adx) && (cpet_pkg::RDIFF_W'(sum_h) > ady);
    end
  end

  always_comb begin
    circ_hit = ((cpet_pkg::SQ_W + 1)'(sq_x) + (cpet_pkg::SQ_W + 1)'(sq_y))
               <= (cpet_pkg::SQ_W + 1)'(sq_r);
    case (shp)
      cpet_pkg::SHAPE_RECT_RECT: hit_c = rect_hit;
      cpet_pkg::SHAPE_CIRC_CIRC: hit_c = circ_hit;
      default:                   hit_c = 1'b0;
    endcase
    was         = rd_row[ri];
    new_row     = rd_row;
    new_row[ri] = hit_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.eval || cmd.clr_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_emit) begin
      event_res <= cpet_pkg::EV_NONE;
      hit       <= 1'b0;
    end else if (cmd.eval) begin
      hit <= hit_c;
      if (hit_c) begin
        event_res <= was ? cpet_pkg::EV_STAY : cpet_pkg::EV_ENTER;
      end else begin
        event_res <= was ? cpet_pkg::EV_EXIT : cpet_pkg::EV_NONE;
      end
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.eval) || $past(cmd.clr_emit))
    else $error("result strobe without a finished item");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_emit |=> done && event_res == cpet_pkg::EV_NONE && !hit)
    else $error("clear item result is not empty");

  a_hit_events: assert property (@(posedge clk) disable iff (rst)
    done && (event_res == cpet_pkg::EV_ENTER || event_res == cpet_pkg::EV_STAY) |-> hit)
    else $error("enter or stay without overlap");

  a_exit_event: assert property (@(posedge clk) disable iff (rst)
    done && event_res == cpet_pkg::EV_EXIT |-> !hit)
    else $error("exit reported with overlap");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_wr && (cmd.eval || cmd.load)))
    else $error("row sweep overlaps a test item");

endmodule
`default_nettype wire

// ===== tb/tb_collision_pair_event_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_collision_pair_event_tracker_core
// Self-checking bench for the collider pair tracker: directed edge cases, then
// random pairs from a small id pool so pairs enter, stay and exit, mixed with
// full-range noise and clears. Results are checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_collision_pair_event_tracker_core;
  import cpet_pkg::*;

  localparam int ID_W           = ID_BITS_DEF;
  localparam int PAIR_COUNT     = 1 << (2 * ID_W);
  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    kind_t                    kind;
    logic [ID_W-1:0]          lid;
    logic [ID_W-1:0]          rid;
    logic signed [POS_W-1:0]  lx;
    logic signed [POS_W-1:0]  ly;
    logic [SIZE_W-1:0]        lw;
    logic [SIZE_W-1:0]        lh;
    logic signed [POS_W-1:0]  rx;
    logic signed [POS_W-1:0]  ry;
    logic [SIZE_W-1:0]        rw;
    logic [SIZE_W-1:0]        rh;
    shape_t                   shapes;
  } pair_item_t;

  typedef struct packed {
    ev_t  ev;
    logic hit;
  } pair_event_t;

  logic       clk   = 1'b0;
  logic       rst   = 1'b1;
  logic       start = 1'b0;
  pair_item_t drv   = '0;
  logic       busy;
  logic       done;
  logic [1:0] event_res;
  logic       hit;

  pair_item_t  pair_items[$];
  pair_event_t pending_events[$];
  bit          pair_contact [0:PAIR_COUNT-1];

  int mismatches     = 0;
  int accepted_items = 0;
  int clears_seen    = 0;
  int hits_seen      = 0;
  int ev_seen [4]    = '{default: 0};
  int idle_cycles    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  pair_event_t want;

  always #10 clk = ~clk;

  collision_pair_event_tracker_core #(
    .ID_BITS(ID_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (drv.kind),
    .left_id  (drv.lid),
    .right_id (drv.rid),
    .left_x   (drv.lx),
    .left_y   (drv.ly),
    .left_w   (drv.lw),
    .left_h   (drv.lh),
    .right_x  (drv.rx),
    .right_y  (drv.ry),
    .right_w  (drv.rw),
    .right_h  (drv.rh),
    .shapes   (drv.shapes),
    .done     (done),
    .event_res(event_res),
    .hit      (hit)
  );

  // overlap test plus the per-pair touching flag update
  function automatic pair_event_t predict_pair_event(pair_item_t it);
    pair_event_t r;
    longint lx, ly, rx, ry, lhw, lhh, rhw, rhh, dx, dy, rad;
    logic overlap;
    logic was;
    int idx;
    r.ev  = EV_NONE;
    r.hit = 1'b0;
    if (it.kind == KIND_CLEAR) begin
      foreach (pair_contact[i]) pair_contact[i] = 1'b0;
      return r;
    end
    lx  = $signed(it.lx);
    ly  = $signed(it.ly);
    rx  = $signed(it.rx);
    ry  = $signed(it.ry);
    lhw = longint'(it.lw) * 50;
    lhh = longint'(it.lh) * 50;
    rhw = longint'(it.rw) * 50;
    rhh = longint'(it.rh) * 50;
    case (it.shapes)
      SHAPE_RECT_RECT: begin
        dx = lx - rx;
        dy = ly - ry;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        overlap = (dx < lhw + rhw) && (dy < lhh + rhh);
      end
      SHAPE_CIRC_CIRC: begin
        // centres sit half a size away from the position, radii from widths only
        dx = (lx + lhw) - (rx + rhw);
        dy = (ly + lhh) - (ry + rhh);
        rad = lhw + rhw;
        overlap = (dx * dx + dy * dy) <= (rad * rad);
      end
      default: overlap = 1'b0;
    endcase
    idx = {it.lid, it.rid};
    was = pair_contact[idx];
    r.hit = overlap;
    if (overlap) begin
      r.ev = was ? EV_STAY : EV_ENTER;
      pair_contact[idx] = 1'b1;
    end else if (was) begin
      r.ev = EV_EXIT;
      pair_contact[idx] = 1'b0;
    end
    return r;
  endfunction

  function automatic pair_item_t pair_test(int lid, int rid, int lx, int ly, int lw, int lh,
                                           int rx, int ry, int rw, int rh, shape_t sh);
    pair_item_t it;
    it.kind   = KIND_TEST;
    it.lid    = lid[ID_W-1:0];
    it.rid    = rid[ID_W-1:0];
    it.lx     = lx[POS_W-1:0];
    it.ly     = ly[POS_W-1:0];
    it.lw     = lw[SIZE_W-1:0];
    it.lh     = lh[SIZE_W-1:0];
    it.rx     = rx[POS_W-1:0];
    it.ry     = ry[POS_W-1:0];
    it.rw     = rw[SIZE_W-1:0];
    it.rh     = rh[SIZE_W-1:0];
    it.shapes = sh;
    return it;
  endfunction

  function automatic pair_item_t clear_item();
    pair_item_t it;
    it      = '0;
    it.kind = KIND_CLEAR;
    return it;
  endfunction

  // one axis of the second collider, placed near the first so tests land both ways
  function automatic int near_pos(int base, int lhalf, int rhalf);
    int span;
    int delta;
    span = lhalf + rhalf;
    case ($urandom_range(0, 7))
      0: delta = span;
      1: delta = -span;
      default: delta = int'($urandom_range(0, 3 * span + 4)) - (3 * span + 4) / 2;
    endcase
    return base + lhalf - rhalf + delta;
  endfunction

  task automatic add_random_items(int count);
    pair_item_t it;
    int roll;
    int lx, ly, lw, lh, rw, rh;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        pair_items.push_back(clear_item());
      end else begin
        it.kind = KIND_TEST;
        // a small id pool keeps pairs coming back so flags get exercised
        it.lid = ID_W'((roll < 75) ? $urandom_range(0, 3)
                                   : $urandom_range(0, (1 << ID_W) - 1));
        it.rid = ID_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, (1 << ID_W) - 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: it.shapes = SHAPE_RECT_RECT;
          8:          it.shapes = SHAPE_CIRC_RECT;
          9:          it.shapes = SHAPE_RECT_CIRC;
          default:    it.shapes = SHAPE_CIRC_CIRC;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          lw = $urandom_range(0, 65535);
          lh = $urandom_range(0, 65535);
          rw = $urandom_range(0, 65535);
          rh = $urandom_range(0, 65535);
        end else begin
          lw = $urandom_range(0, 600);
          lh = $urandom_range(0, 600);
          rw = $urandom_range(0, 600);
          rh = $urandom_range(0, 600);
        end
        if ($urandom_range(0, 9) == 0) begin
          lx = $urandom();
          ly = $urandom();
        end else begin
          lx = int'($urandom_range(0, 1 << 21)) - (1 << 20);
          ly = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        it.lx = lx[POS_W-1:0];
        it.ly = ly[POS_W-1:0];
        it.lw = lw[SIZE_W-1:0];
        it.lh = lh[SIZE_W-1:0];
        it.rw = rw[SIZE_W-1:0];
        it.rh = rh[SIZE_W-1:0];
        if ($urandom_range(0, 4) != 0) begin
          it.rx = POS_W'(near_pos(lx, lw * 50, rw * 50));
          it.ry = POS_W'(near_pos(ly, lh * 50, rh * 50));
        end else begin
          it.rx = POS_W'($urandom());
          it.ry = POS_W'($urandom());
        end
        pair_items.push_back(it);
      end
    end
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_events.push_back(predict_pair_event(drv));
        accepted_items++;
        if (drv.kind == KIND_CLEAR) clears_seen++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (pair_items.size() > 0) begin
          drv   <= pair_items.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobed result against the oldest expected event
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: event %0d hit %0b",
                                event_res, hit));
      end else begin
        want = pending_events.pop_front();
        if (event_res !== want.ev || hit !== want.hit) begin
          note_mismatch($sformatf("event exp %0d got %0d, hit exp %0b got %0b",
                                  want.ev, event_res, want.hit, hit));
        end
        ev_seen[want.ev]++;
        if (want.hit) hits_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pair_event_t missing;
    // touching pair enters, stays, exits, then stays apart
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 900000, 0, 256, 256,
                                   SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 900000, 0, 256, 256,
                                   SHAPE_RECT_RECT));
    // rect edges touching exactly do not count, one step inside does
    pair_items.push_back(pair_test(3, 4, 0, 0, 1, 1, 100, 0, 1, 1, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(3, 4, 0, 0, 1, 1, 99, 0, 1, 1, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(3, 4, 0, 0, 1, 1, 0, -100, 1, 1, SHAPE_RECT_RECT));
    // circles: tangent counts, one past does not, tangent on a diagonal
    pair_items.push_back(pair_test(5, 6, 0, 0, 1, 0, 100, 0, 1, 0, SHAPE_CIRC_CIRC));
    pair_items.push_back(pair_test(5, 6, 0, 0, 1, 0, 101, 0, 1, 0, SHAPE_CIRC_CIRC));
    pair_items.push_back(pair_test(5, 6, 0, 80, 1, 0, 60, 0, 1, 0, SHAPE_CIRC_CIRC));
    // mixed shapes always miss, even fully overlapped
    pair_items.push_back(pair_test(5, 6, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_CIRC_RECT));
    pair_items.push_back(pair_test(7, 8, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_CIRC));
    // same id on both sides, and the two orders of one pair
    pair_items.push_back(pair_test(9, 9, 10, 10, 4, 4, 20, 20, 4, 4, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(2, 1, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(2, 1, 0, 0, 1, 1, 500, 0, 1, 1, SHAPE_RECT_RECT));
    // zero sizes: rects never touch, circles at one point do
    pair_items.push_back(pair_test(10, 11, 7, 7, 0, 0, 7, 7, 0, 0, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(10, 12, 7, 7, 0, 0, 7, 7, 0, 0, SHAPE_CIRC_CIRC));
    // position and size extremes
    pair_items.push_back(pair_test(63, 0, -8388608, 8388607, 65535, 65535,
                                   8388607, -8388608, 65535, 65535, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(63, 63, -8388608, -8388608, 65535, 65535,
                                   -8388608, -8388608, 65535, 65535, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(0, 63, 8388607, 8388607, 65535, 65535,
                                   -8388608, -8388608, 65535, 65535, SHAPE_CIRC_CIRC));
    pair_items.push_back(pair_test(0, 63, 8388607, 8388607, 65535, 65535,
                                   8388607, 8388607, 65535, 65535, SHAPE_CIRC_CIRC));
    // clear drops every flag, so touching pairs enter again
    pair_items.push_back(clear_item());
    pair_items.push_back(pair_test(1, 2, 0, 0, 256, 256, 0, 0, 256, 256, SHAPE_RECT_RECT));
    pair_items.push_back(pair_test(9, 9, 10, 10, 4, 4, 20, 20, 4, 4, SHAPE_RECT_RECT));
    add_random_items(RANDOM_ITEMS);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pair_items.size() != 0 || start || pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_events.size() != 0) begin
      missing = pending_events.pop_front();
      note_mismatch($sformatf("no result for expected event %0d hit %0b",
                              missing.ev, missing.hit));
    end

    $display("ran %0d items (%0d clears), %0d hits", accepted_items, clears_seen, hits_seen);
    $display("events seen: none %0d, enter %0d, stay %0d, exit %0d",
             ev_seen[EV_NONE], ev_seen[EV_ENTER], ev_seen[EV_STAY], ev_seen[EV_EXIT]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cpet_pkg.sv
sv/cpet_ctrl.sv
sv/cpet_dp.sv
sv/collision_pair_event_tracker_core.sv
tb/tb_collision_pair_event_tracker_core.sv
